// ===== hw/rtl/bdda_pkg.sv =====
`timescale 1ns / 1ps

package bdda_pkg;

    localparam int DAY_COUNT_BITS_DEF = 12;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int WDAY_W  = 3;
    localparam int CNT_W   = 12;

    localparam logic [YEAR_W-1:0]  MAX_YEAR    = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR   = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [WDAY_W-1:0]  WD_SUNDAY   = 3'd0;
    localparam logic [WDAY_W-1:0]  WD_FRIDAY   = 3'd5;
    localparam logic [WDAY_W-1:0]  WD_SATURDAY = 3'd6;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    // year within its century and century mod 4, enough for the leap rule
    typedef struct packed {
        logic [6:0] yc;
        logic [1:0] cmod4;
    } yphase_t;

    typedef struct packed {
        date_t             date;
        yphase_t           phase;
        logic [WDAY_W-1:0] weekday;
    } cal_t;

    typedef struct packed {
        logic              done;
        logic [WDAY_W-1:0] weekday;
        yphase_t           phase;
    } wd_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WDAY,
        ST_SKIP_IN,
        ST_COUNT,
        ST_SKIP_OUT,
        ST_FINISH
    } state_t;

    function automatic logic is_leap(input yphase_t p);
        logic leap;
        if (p.yc == 7'd0) begin
            leap = (p.cmod4 == 2'd0);
        end else begin
            leap = (p.yc[1:0] == 2'd0);
        end
        return leap;
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = leap ? 5'd29 : 5'd28;
            default:                                     n = 5'd0;
        endcase
        return n;
    endfunction

    // floor(31 * mm / 12) for the shifted month number mm
    function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] mm);
        logic [DAY_W-1:0] o;
        unique case (mm)
            4'd1:    o = 5'd2;
            4'd2:    o = 5'd5;
            4'd3:    o = 5'd7;
            4'd4:    o = 5'd10;
            4'd5:    o = 5'd12;
            4'd6:    o = 5'd15;
            4'd7:    o = 5'd18;
            4'd8:    o = 5'd20;
            4'd9:    o = 5'd23;
            4'd10:   o = 5'd25;
            4'd11:   o = 5'd28;
            4'd12:   o = 5'd31;
            default: o = 5'd0;
        endcase
        return o;
    endfunction

    function automatic logic is_weekend(input logic [WDAY_W-1:0] wd);
        return (wd == WD_FRIDAY) || (wd == WD_SATURDAY);
    endfunction

endpackage

// ===== hw/rtl/business_day_date_adder_unit.sv =====
`timescale 1ns / 1ps

// Business-day date adder. Friday and Saturday are weekend days.
// Input channel s_*: a start date and a count of business days, one transaction
// per item; s_ready is high only while the unit is idle.
// Result channel m_*: return date, its weekday (0 is Sunday) and an error flag.
// An invalid start date, or stepping past 31 December 9999, returns the start
// date unchanged with weekday 0 and error set.
// After acceptance the start weekday is computed in the shared constant
// multiplier; the day-step unit then steps the calendar a day at a time, with a
// check at the end of each of the three phases, and the output register is
// loaded last. The count is capped by DAY_COUNT_BITS. One item is in flight at a
// time; the next transaction is taken at the edge after m_valid rises.
// The output register holds a result until m_ready; the next transaction can be
// taken while it waits, but a finished item waits for the register to free.
// Reset (aresetn low, synchronous) drops m_valid and returns the unit to idle.
module business_day_date_adder_unit #(
    parameter int DAY_COUNT_BITS = bdda_pkg::DAY_COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bdda_pkg::DAY_W-1:0]     s_start_day,
    input  logic [bdda_pkg::MONTH_W-1:0]   s_start_month,
    input  logic [bdda_pkg::YEAR_W-1:0]    s_start_year,
    input  logic [bdda_pkg::CNT_W-1:0]     s_business_days,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bdda_pkg::DAY_W-1:0]     m_return_day,
    output logic [bdda_pkg::MONTH_W-1:0]   m_return_month,
    output logic [bdda_pkg::YEAR_W-1:0]    m_return_year,
    output logic [bdda_pkg::WDAY_W-1:0]    m_return_weekday,
    output logic                           m_error
);
    import bdda_pkg::*;

    state_t                    state_reg, state_next;
    date_t                     start_reg;
    cal_t                      cal_reg, cal_next;
    logic [DAY_COUNT_BITS-1:0] remain_reg, remain_next;
    logic                      err_reg, err_next;
    logic                      m_valid_reg, m_valid_next;
    date_t                     out_date_reg;
    logic [WDAY_W-1:0]         out_wd_reg;
    logic                      out_err_reg;

    logic       accept;
    date_t      in_date;
    wd_status_t wd_status;
    cal_t       step_cal;
    logic       step_ovf;
    logic       weekend;
    logic       date_ok;
    logic       out_free;
    logic       stepping;

    assign accept        = s_valid && s_ready;
    assign in_date.day   = s_start_day;
    assign in_date.month = s_start_month;
    assign in_date.year  = s_start_year;

    bdda_weekday u_weekday (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .date    (in_date),
        .status  (wd_status)
    );

    bdda_day_step u_step (
        .cur      (cal_reg),
        .nxt      (step_cal),
        .overflow (step_ovf)
    );

    assign weekend  = is_weekend(cal_reg.weekday);
    assign out_free = !m_valid_reg || m_ready;
    assign date_ok  = (start_reg.month != 4'd0) && (start_reg.month <= MONTH_DEC)
                   && (start_reg.year != 14'd0) && (start_reg.year <= MAX_YEAR)
                   && (start_reg.day != 5'd0)
                   && (start_reg.day <= days_in_month(start_reg.month,
                                                      is_leap(wd_status.phase)));

    // a day step is wanted in this cycle
    assign stepping = ((state_reg == ST_SKIP_IN) && weekend)
                   || ((state_reg == ST_COUNT) && (remain_reg != '0))
                   || ((state_reg == ST_SKIP_OUT) && weekend);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_WDAY;
            ST_WDAY:     if (wd_status.done) state_next = date_ok ? ST_SKIP_IN : ST_FINISH;
            ST_SKIP_IN: begin
                if (!weekend) state_next = ST_COUNT;
                else if (step_ovf) state_next = ST_FINISH;
            end
            ST_COUNT: begin
                if (remain_reg == '0) state_next = ST_SKIP_OUT;
                else if (step_ovf) state_next = ST_FINISH;
            end
            ST_SKIP_OUT: if (!weekend || step_ovf) state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cal_next     = cal_reg;
        remain_next  = remain_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        if (accept) begin
            err_next    = 1'b0;
            remain_next = DAY_COUNT_BITS'(s_business_days);
        end
        if ((state_reg == ST_WDAY) && wd_status.done) begin
            cal_next.date    = start_reg;
            cal_next.phase   = wd_status.phase;
            cal_next.weekday = wd_status.weekday;
            err_next         = !date_ok;
        end
        if (stepping) begin
            if (step_ovf) begin
                err_next = 1'b1;
            end else begin
                cal_next = step_cal;
                if ((state_reg == ST_COUNT) && !weekend) begin
                    remain_next = remain_reg - DAY_COUNT_BITS'(1);
                end
            end
        end
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            start_reg <= in_date;
        end
        cal_reg    <= cal_next;
        remain_reg <= remain_next;
        err_reg    <= err_next;
        if ((state_reg == ST_FINISH) && out_free) begin
            out_err_reg <= err_reg;
            if (err_reg) begin
                out_date_reg <= start_reg;
                out_wd_reg   <= WD_SUNDAY;
            end else begin
                out_date_reg <= cal_reg.date;
                out_wd_reg   <= cal_reg.weekday;
            end
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_return_day     = out_date_reg.day;
    assign m_return_month   = out_date_reg.month;
    assign m_return_year    = out_date_reg.year;
    assign m_return_weekday = out_wd_reg;
    assign m_error          = out_err_reg;

endmodule

// ===== hw/rtl/bdda_weekday.sv =====
`timescale 1ns / 1ps

module bdda_weekday (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  bdda_pkg::date_t     date,
    output bdda_pkg::wd_status_t status
);
    import bdda_pkg::*;

    localparam logic [14:0] RECIP_100 = 15'd5243;   // 2^19 / 100, rounded up
    localparam logic [14:0] RECIP_7   = 15'd18725;  // 2^17 / 7, rounded up
    localparam logic [2:0]  LAST_STEP = 3'd5;

    logic [2:0]         step_reg, step_next;
    logic               done_reg, done_next;
    logic [DAY_W-1:0]   day_reg;
    logic [YEAR_W-1:0]  y_reg;
    logic [YEAR_W-1:0]  yy_reg;
    logic [MONTH_W-1:0] mm_reg;
    logic [7:0]         cy_reg;
    logic [7:0]         cyy_reg;
    logic [6:0]         yc_reg;
    logic [14:0]        sum_reg;
    logic [11:0]        q7_reg;
    logic [WDAY_W-1:0]  wd_reg;

    logic [14:0] mul_a;
    logic [14:0] mul_k;
    logic [29:0] prod;
    logic [14:0] cy_x100;
    logic [14:0] q7_x7;
    logic [14:0] sum_next;
    logic        early;

    // one shared constant multiplier serves both divisions by 100 and the mod 7
    always_comb begin
        mul_a = {1'b0, y_reg};
        mul_k = RECIP_100;
        unique case (step_reg)
            3'd2:    mul_a = {1'b0, yy_reg};
            3'd4: begin
                mul_a = sum_reg;
                mul_k = RECIP_7;
            end
            default: mul_a = {1'b0, y_reg};
        endcase
    end

    assign prod    = mul_a * mul_k;
    assign cy_x100 = {7'd0, cy_reg} * 15'd100;
    assign q7_x7   = {3'd0, q7_reg} * 15'd7;
    assign early   = (date.month < MONTH_MAR);

    assign sum_next = {10'd0, day_reg} + {1'b0, yy_reg} + {3'd0, yy_reg[13:2]}
                    - {7'd0, cyy_reg} + {9'd0, cyy_reg[7:2]}
                    + {10'd0, month_offset(mm_reg)};

    always_comb begin
        step_next = step_reg;
        done_next = 1'b0;
        if (start) begin
            step_next = 3'd1;
        end else if (step_reg == LAST_STEP) begin
            step_next = 3'd0;
            done_next = 1'b1;
        end else if (step_reg != 3'd0) begin
            step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            day_reg <= date.day;
            y_reg   <= date.year;
            yy_reg  <= date.year - {13'd0, early};
            mm_reg  <= early ? (date.month + 4'd10) : (date.month - MONTH_FEB);
        end
        unique case (step_reg)
            3'd1: cy_reg  <= prod[26:19];
            3'd2: begin
                cyy_reg <= prod[26:19];
                yc_reg  <= 7'(y_reg - cy_x100[13:0]);
            end
            3'd3: sum_reg <= sum_next;
            3'd4: q7_reg  <= prod[28:17];
            3'd5: wd_reg  <= 3'(sum_reg - q7_x7);
            default: ;
        endcase
    end

    assign status.done        = done_reg;
    assign status.weekday     = wd_reg;
    assign status.phase.yc    = yc_reg;
    assign status.phase.cmod4 = cy_reg[1:0];

endmodule

// ===== hw/rtl/bdda_day_step.sv =====
`timescale 1ns / 1ps

module bdda_day_step (
    input  bdda_pkg::cal_t cur,
    output bdda_pkg::cal_t nxt,
    output logic           overflow
);
    import bdda_pkg::*;

    logic             month_end;
    logic [DAY_W-1:0] dim;

    assign dim       = days_in_month(cur.date.month, is_leap(cur.phase));
    assign month_end = (cur.date.day >= dim);
    assign overflow  = month_end && (cur.date.month == MONTH_DEC) && (cur.date.year >= MAX_YEAR);

    always_comb begin
        nxt         = cur;
        nxt.weekday = (cur.weekday == WD_SATURDAY) ? WD_SUNDAY : cur.weekday + 3'd1;
        if (!month_end) begin
            nxt.date.day = cur.date.day + 5'd1;
        end else if (cur.date.month != MONTH_DEC) begin
            nxt.date.day   = 5'd1;
            nxt.date.month = cur.date.month + 4'd1;
        end else begin
            nxt.date.day   = 5'd1;
            nxt.date.month = 4'd1;
            nxt.date.year  = cur.date.year + 14'd1;
            // year within century wraps into the next century
            if (cur.phase.yc == 7'd99) begin
                nxt.phase.yc    = 7'd0;
                nxt.phase.cmod4 = cur.phase.cmod4 + 2'd1;
            end else begin
                nxt.phase.yc = cur.phase.yc + 7'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/bdda_checker.sv =====
`timescale 1ns / 1ps

module bdda_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [bdda_pkg::DAY_W-1:0]   m_return_day,
    input logic [bdda_pkg::MONTH_W-1:0] m_return_month,
    input logic [bdda_pkg::YEAR_W-1:0]  m_return_year,
    input logic [bdda_pkg::WDAY_W-1:0]  m_return_weekday,
    input logic                         m_error
);
    import bdda_pkg::*;

    // the unit works one item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready still high after a transaction was taken");

    a_no_weekend_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error |->
            (m_return_weekday != WD_FRIDAY) && (m_return_weekday != WD_SATURDAY))
        else $error("return date falls on a weekend");

    a_error_weekday: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> (m_return_weekday == WD_SUNDAY))
        else $error("error result with nonzero weekday");

    a_valid_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error |-> (m_return_month != 4'd0) && (m_return_month <= MONTH_DEC)
            && (m_return_day != 5'd0) && (m_return_year != 14'd0)
            && (m_return_year <= MAX_YEAR))
        else $error("return date out of range");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_return_day)
            && $stable(m_return_month) && $stable(m_return_year)
            && $stable(m_return_weekday) && $stable(m_error))
        else $error("result changed while stalled");

endmodule

bind business_day_date_adder_unit bdda_checker u_bdda_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bdda_pkg::*;

    localparam int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF;
    localparam int RANDOM_ITEMS   = 76;
    localparam int MAX_GAP        = 18;
    localparam int TAIL_CYCLES    = 20;
    localparam int CYCLE_LIMIT    = 2000000;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [WDAY_W-1:0]  weekday;
        logic               error;
    } return_t;

    typedef struct {
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned wd;
    } cal_pos_t;

    // holds predicted return dates in order of accepted requests
    class return_date_board;
        return_t     awaited[$];
        int unsigned failures;
        int unsigned accepted;
        int unsigned flagged;
        int unsigned long_runs;

        function bit leap_year(int unsigned y);
            return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        endfunction

        function int unsigned month_days(int unsigned y, int unsigned m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        function int unsigned weekday_from_date(int unsigned d, int unsigned m,
                                                int unsigned y);
            int unsigned a;
            int unsigned yy;
            int unsigned mm;
            a  = (14 - m) / 12;
            yy = y - a;
            mm = m + 12 * a - 2;
            return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
        endfunction

        function bit off_day(int unsigned wd);
            return wd == int'(WD_FRIDAY) || wd == int'(WD_SATURDAY);
        endfunction

        // one calendar day forward; 0 when the year would pass the last one
        function bit advance_day(inout cal_pos_t p);
            if (p.d >= month_days(p.y, p.m)) begin
                if (p.m == int'(MONTH_DEC)) begin
                    if (p.y >= int'(MAX_YEAR)) return 1'b0;
                    p.d = 1;
                    p.m = 1;
                    p.y = p.y + 1;
                end else begin
                    p.d = 1;
                    p.m = p.m + 1;
                end
            end else begin
                p.d = p.d + 1;
            end
            p.wd = (p.wd + 1) % 7;
            return 1'b1;
        endfunction

        function return_t add_business_days(int unsigned sd, int unsigned sm,
                                            int unsigned sy, int unsigned cnt);
            cal_pos_t    p;
            int unsigned done;
            bit          ok;
            return_t     r;
            cnt  = cnt & ((1 << DAY_COUNT_BITS) - 1);
            p    = '{d: sd, m: sm, y: sy, wd: 0};
            done = 0;
            ok   = 1'b1;
            if (sm < 1 || sm > 12 || sy < 1 || sy > int'(MAX_YEAR) ||
                sd < 1 || sd > month_days(sy, sm)) begin
                ok = 1'b0;
            end else begin
                p.wd = weekday_from_date(sd, sm, sy);
                while (ok && off_day(p.wd)) ok = advance_day(p);
                while (ok && done < cnt) begin
                    if (!off_day(p.wd)) done++;
                    ok = advance_day(p);
                end
                while (ok && off_day(p.wd)) ok = advance_day(p);
            end
            if (!ok) p = '{d: sd, m: sm, y: sy, wd: 0};
            r.day     = p.d[DAY_W-1:0];
            r.month   = p.m[MONTH_W-1:0];
            r.year    = p.y[YEAR_W-1:0];
            r.weekday = p.wd[WDAY_W-1:0];
            r.error   = !ok;
            return r;
        endfunction

        function void note_request(int unsigned sd, int unsigned sm, int unsigned sy,
                                   int unsigned cnt);
            return_t r;
            r = add_business_days(sd, sm, sy, cnt);
            awaited.push_back(r);
            accepted++;
            if (r.error) flagged++;
            if (cnt >= 1024) long_runs++;
        endfunction

        function void check_return(return_t got);
            return_t want;
            if (awaited.size() == 0) begin
                $error("result transaction with nothing outstanding");
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.day !== want.day) begin
                $error("return_day: expected %0d, actual %0d", want.day, got.day);
                failures++;
            end
            if (got.month !== want.month) begin
                $error("return_month: expected %0d, actual %0d", want.month, got.month);
                failures++;
            end
            if (got.year !== want.year) begin
                $error("return_year: expected %0d, actual %0d", want.year, got.year);
                failures++;
            end
            if (got.weekday !== want.weekday) begin
                $error("return_weekday: expected %0d, actual %0d",
                       want.weekday, got.weekday);
                failures++;
            end
            if (got.error !== want.error) begin
                $error("error: expected %0d, actual %0d", want.error, got.error);
                failures++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [DAY_W-1:0]     s_start_day     = '0;
    logic [MONTH_W-1:0]   s_start_month   = '0;
    logic [YEAR_W-1:0]    s_start_year    = '0;
    logic [CNT_W-1:0]     s_business_days = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [DAY_W-1:0]     m_return_day;
    logic [MONTH_W-1:0]   m_return_month;
    logic [YEAR_W-1:0]    m_return_year;
    logic [WDAY_W-1:0]    m_return_weekday;
    logic                 m_error;

    return_date_board board = new();
    bit               no_idle = 1'b0;
    int unsigned      cycles  = 0;

    business_day_date_adder_unit #(
        .DAY_COUNT_BITS(DAY_COUNT_BITS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_day      (s_start_day),
        .s_start_month    (s_start_month),
        .s_start_year     (s_start_year),
        .s_business_days  (s_business_days),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_return_day     (m_return_day),
        .m_return_month   (m_return_month),
        .m_return_year    (m_return_year),
        .m_return_weekday (m_return_weekday),
        .m_error          (m_error)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(int unsigned d, int unsigned m, int unsigned y,
                                int unsigned cnt);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_start_day     <= d[DAY_W-1:0];
        s_start_month   <= m[MONTH_W-1:0];
        s_start_year    <= y[YEAR_W-1:0];
        s_business_days <= cnt[CNT_W-1:0];
        do @(posedge aclk); while (!s_ready);
        board.note_request(d[DAY_W-1:0], m[MONTH_W-1:0], y[YEAR_W-1:0],
                           cnt[CNT_W-1:0]);
        @(negedge aclk);
    endtask

    // result side with random back-pressure
    initial begin
        int unsigned stall;
        return_t     got;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{day: m_return_day, month: m_return_month, year: m_return_year,
                    weekday: m_return_weekday, error: m_error};
            board.check_return(got);
            @(negedge aclk);
        end
    end

    initial begin
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned cnt;
        int unsigned pick;
        int unsigned sel;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // weekend starts, zero counts, first and last representable dates
        send_request(1, 1, 2000, 0);
        send_request(1, 3, 2024, 0);
        send_request(1, 1, 1, 0);
        send_request(1, 1, 1, 1);
        send_request(31, 12, 9999, 0);
        send_request(30, 12, 9999, 1);
        send_request(1, 1, 9999, 4095);
        send_request(15, 6, 2023, 4095);
        // leap rules: century years, leap day, one past
        send_request(29, 2, 2024, 3);
        send_request(29, 2, 2023, 3);
        send_request(29, 2, 1900, 1);
        send_request(29, 2, 2000, 1);
        send_request(30, 2, 2000, 1);
        send_request(28, 2, 2100, 2);
        // malformed dates, with one valid end-of-month date among them
        send_request(31, 4, 2022, 5);
        send_request(0, 5, 2022, 5);
        send_request(31, 1, 2022, 5);
        send_request(10, 0, 2022, 5);
        send_request(10, 13, 2022, 5);
        send_request(31, 15, 16383, 4095);
        send_request(10, 6, 0, 5);
        send_request(10, 6, 10000, 5);
        // year boundary and a plain work week
        send_request(28, 12, 2023, 3);
        send_request(7, 1, 2024, 5);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 40 && i < 60);
            pick = $urandom_range(0, 9);
            sel  = $urandom_range(0, 19);
            if (sel == 0) begin
                cnt = $urandom_range(1024, 4095);
            end else if (sel <= 3) begin
                cnt = $urandom_range(0, 7);
            end else begin
                cnt = $urandom_range(0, 255);
            end
            if (pick < 2) begin
                // raw field noise, mostly malformed
                d   = $urandom_range(0, 31);
                m   = $urandom_range(0, 15);
                y   = $urandom_range(0, 16383);
                cnt = $urandom_range(0, 63);
            end else if (pick == 2) begin
                // close to the end of the calendar
                y = MAX_YEAR;
                m = $urandom_range(11, 12);
                d = $urandom_range(1, board.month_days(y, m));
            end else begin
                y = $urandom_range(1, 9999);
                m = $urandom_range(1, 12);
                d = $urandom_range(1, board.month_days(y, m));
            end
            send_request(d, m, y, cnt);
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d flagged invalid or past the last year,",
                 board.accepted, board.flagged);
        $display("%0d with counts of 1024 business days or more", board.long_runs);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bdda_pkg.sv
hw/rtl/bdda_weekday.sv
hw/rtl/bdda_day_step.sv
hw/rtl/business_day_date_adder_unit.sv
hw/rtl/bdda_checker.sv
tb/sv/tb.sv
